// File: hw/rtl/bbia_pkg.sv
// ----------------------------------------------------------------------------
// bbia_pkg
// Constants, codes and helper functions for the block and inode allocator.
// ----------------------------------------------------------------------------
package bbia_pkg;

  localparam int BLOCK_COUNT      = 4096;
  localparam int INODE_TOTAL      = 2048;
  localparam int FIRST_DATA_BLOCK = 132;

  // bitmap rows: one memory word holds MAP_W map bits
  localparam int MAP_W    = 64;
  localparam int BIT_AW   = $clog2(MAP_W);
  localparam int BLK_ROWS = BLOCK_COUNT / MAP_W;
  localparam int INO_ROWS = INODE_TOTAL / MAP_W;
  localparam int BROW_AW  = $clog2(BLK_ROWS);
  localparam int IROW_AW  = $clog2(INO_ROWS);
  localparam int BLK_W    = BROW_AW + BIT_AW;
  localparam int INO_W    = IROW_AW + BIT_AW;
  localparam int HWM_W    = $clog2(INODE_TOTAL + 1);

  typedef enum logic [1:0] {
    REQ_FORMAT = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_NO_INODE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_BSCAN,
    S_ISCAN
  } state_t;

  // Position of the lowest set bit of a map word.
  function automatic logic [BIT_AW-1:0] lowest_bit(input logic [MAP_W-1:0] w);
    logic [BIT_AW-1:0] p;
    p = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (w[b]) p = BIT_AW'(b);
    end
    return p;
  endfunction

  // Free-block row as left by format: blocks below the data area stay used.
  function automatic logic [MAP_W-1:0] blk_reset_row(input logic [BROW_AW-1:0] row);
    logic [MAP_W-1:0] w;
    for (int b = 0; b < MAP_W; b++) begin
      w[b] = ({row, BIT_AW'(b)} >= BLK_W'(FIRST_DATA_BLOCK));
    end
    return w;
  endfunction

endpackage

// File: hw/rtl/bbia_ram.sv
// ----------------------------------------------------------------------------
// bbia_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bitmap_block_and_inode_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_block_and_inode_allocator_core
// Free-block / free-inode bitmap allocator with a per-inode first-block table.
// ----------------------------------------------------------------------------
// Format and unused requests strobe their result in the cycle after accept;
// lookup passes through the lookup state and then the done register; create
// scans block rows until a free bit, then inode rows, reading one row at a time.
// One item at a time: busy stays high until the result cycle, and the next
// item can be taken at the edge that ends it; format and unused never raise it.
// Reset (synchronous, rst high) puts both bitmaps in the formatted state at
// once through per-row valid flags; table entries never allocated read zero
// through an allocation high-water count. The receiver cannot stall results.
module bitmap_block_and_inode_allocator_core
  import bbia_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [INO_W-1:0] inode_id,
  output logic             done,
  output logic [1:0]       status,
  output logic [INO_W-1:0] new_inode,
  output logic [BLK_W-1:0] block_number
);

  localparam logic [BROW_AW-1:0] BROW_LAST = BROW_AW'(BLK_ROWS - 1);
  localparam logic [IROW_AW-1:0] IROW_LAST = IROW_AW'(INO_ROWS - 1);

  state_t state, state_next;

  logic [BROW_AW-1:0]  bptr, bptr_next;
  logic [IROW_AW-1:0]  iptr, iptr_next;
  logic [BLK_ROWS-1:0] blk_vld;
  logic [INO_ROWS-1:0] ino_vld;
  logic [HWM_W-1:0]    hwm;
  logic                look_hit, look_hit_next;
  logic [MAP_W-1:0]    blk_word;
  logic [BIT_AW-1:0]   blk_bit;

  logic [MAP_W-1:0]  blk_rdata, ino_rdata, blk_eff, ino_eff;
  logic              blk_any, ino_any;
  logic [BIT_AW-1:0] bbit, ibit;
  logic [BLK_W-1:0]  tbl_rdata;
  logic [INO_W-1:0]  ino_num;
  logic [BLK_W-1:0]  blk_num;

  logic             fmt, commit, res_vld;
  status_t          res_status;
  logic [INO_W-1:0] res_inode;
  logic [BLK_W-1:0] res_block;

  assign busy = (state != S_IDLE);

  // rows never written since format read as their formatted value
  assign blk_eff = blk_vld[bptr] ? blk_rdata : blk_reset_row(bptr);
  assign ino_eff = ino_vld[iptr] ? ino_rdata : '1;
  assign blk_any = |blk_eff;
  assign ino_any = |ino_eff;
  assign bbit    = lowest_bit(blk_eff);
  assign ibit    = lowest_bit(ino_eff);
  assign ino_num = {iptr, ibit};
  assign blk_num = {bptr, blk_bit};

  bbia_ram #(.WIDTH(MAP_W), .DEPTH(BLK_ROWS)) u_blk_map (
    .clk   (clk),
    .we    (commit),
    .waddr (bptr),
    .wdata (blk_word & ~(MAP_W'(1) << blk_bit)),
    .raddr (bptr_next),
    .rdata (blk_rdata)
  );

  bbia_ram #(.WIDTH(MAP_W), .DEPTH(INO_ROWS)) u_ino_map (
    .clk   (clk),
    .we    (commit),
    .waddr (iptr),
    .wdata (ino_eff & ~(MAP_W'(1) << ibit)),
    .raddr (iptr_next),
    .rdata (ino_rdata)
  );

  bbia_ram #(.WIDTH(BLK_W), .DEPTH(INODE_TOTAL)) u_first_blk (
    .clk   (clk),
    .we    (commit),
    .waddr (ino_num),
    .wdata (blk_num),
    .raddr (inode_id),
    .rdata (tbl_rdata)
  );

  always_comb begin : next_state_logic
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type))
            REQ_CREATE: state_next = S_BSCAN;
            REQ_LOOKUP: state_next = S_LOOKUP;
            REQ_FORMAT: state_next = S_IDLE;
            REQ_NONE:   state_next = S_IDLE;
          endcase
        end
      end
      S_LOOKUP: state_next = S_IDLE;
      S_BSCAN: begin
        if (blk_any) state_next = S_ISCAN;
        else if (bptr == BROW_LAST) state_next = S_IDLE;
      end
      S_ISCAN: begin
        if (ino_any || iptr == IROW_LAST) state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin : output_logic
    bptr_next     = bptr;
    iptr_next     = iptr;
    look_hit_next = look_hit;
    fmt           = 1'b0;
    commit        = 1'b0;
    res_vld       = 1'b0;
    res_status    = ST_OK;
    res_inode     = '0;
    res_block     = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type))
            REQ_FORMAT: begin
              fmt     = 1'b1;
              res_vld = 1'b1;
            end
            REQ_CREATE: bptr_next = '0;
            REQ_LOOKUP: look_hit_next = (HWM_W'(inode_id) < hwm);
            REQ_NONE:   res_vld = 1'b1;
          endcase
        end
      end
      S_LOOKUP: begin
        res_vld   = 1'b1;
        res_block = look_hit ? tbl_rdata : '0;
      end
      S_BSCAN: begin
        if (blk_any) begin
          iptr_next = '0;
        end else if (bptr == BROW_LAST) begin
          res_vld    = 1'b1;
          res_status = ST_NO_BLOCK;
        end else begin
          bptr_next = bptr + 1'b1;
        end
      end
      S_ISCAN: begin
        if (ino_any) begin
          commit    = 1'b1;
          res_vld   = 1'b1;
          res_inode = ino_num;
          res_block = blk_num;
        end else if (iptr == IROW_LAST) begin
          res_vld    = 1'b1;
          res_status = ST_NO_INODE;
        end else begin
          iptr_next = iptr + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      blk_vld <= '0;
      ino_vld <= '0;
      hwm     <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_vld;
      if (fmt) begin
        blk_vld <= '0;
        ino_vld <= '0;
      end else if (commit) begin
        blk_vld[bptr] <= 1'b1;
        ino_vld[iptr] <= 1'b1;
        // allocation is always lowest-first, so written entries form a prefix
        if (HWM_W'(ino_num) >= hwm) hwm <= HWM_W'(ino_num) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bptr     <= bptr_next;
    iptr     <= iptr_next;
    look_hit <= look_hit_next;
    if (state == S_BSCAN && blk_any) begin
      blk_word <= blk_eff;
      blk_bit  <= bbit;
    end
    status       <= res_status;
    new_inode    <= res_inode;
    block_number <= res_block;
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the block and inode allocator. A driver feeds
// format, create, lookup and unused requests with random gaps. A monitor
// checks every strobed reply against a predictor that keeps its own block
// and inode bitmaps and first-block table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bbia_pkg::*;

  typedef struct packed {
    req_t             req;
    logic [INO_W-1:0] id;
  } fs_req_t;

  typedef struct packed {
    status_t          status;
    logic [INO_W-1:0] inode;
    logic [BLK_W-1:0] block;
  } fs_reply_t;

  logic             clk;
  logic             rst;
  logic             start = 1'b0;
  logic [1:0]       req_type = REQ_NONE;
  logic [INO_W-1:0] inode_id = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [INO_W-1:0] new_inode;
  logic [BLK_W-1:0] block_number;

  bitmap_block_and_inode_allocator_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .inode_id     (inode_id),
    .done         (done),
    .status       (status),
    .new_inode    (new_inode),
    .block_number (block_number)
  );

  // predictor state
  bit               blk_free [BLOCK_COUNT];
  bit               ino_free [INODE_TOTAL];
  logic [BLK_W-1:0] first_blk [INODE_TOTAL];

  fs_req_t   waiting_items [$];
  fs_reply_t owed_replies [$];
  fs_req_t   cur;
  int        items_total;
  int        items_taken;
  int        gap_left;
  bit        steady;
  bit        hold;
  int        errors;
  int        n_create, n_lookup, n_format, n_unused, n_refused;

  function automatic void format_maps();
    for (int b = 0; b < BLOCK_COUNT; b++) blk_free[b] = (b >= FIRST_DATA_BLOCK);
    for (int n = 0; n < INODE_TOTAL; n++) ino_free[n] = 1'b1;
  endfunction

  function automatic fs_reply_t alloc_outcome(input fs_req_t it);
    fs_reply_t r;
    int        blk;
    int        ino;
    r.status = ST_OK;
    r.inode  = '0;
    r.block  = '0;
    blk      = -1;
    ino      = -1;
    case (it.req)
      REQ_FORMAT: format_maps();
      REQ_CREATE: begin
        for (int b = 0; b < BLOCK_COUNT; b++) begin
          if (blk_free[b]) begin
            blk = b;
            break;
          end
        end
        for (int n = 0; n < INODE_TOTAL; n++) begin
          if (ino_free[n]) begin
            ino = n;
            break;
          end
        end
        // block shortage wins over inode shortage
        if (blk < 0) r.status = ST_NO_BLOCK;
        else if (ino < 0) r.status = ST_NO_INODE;
        else begin
          blk_free[blk]  = 1'b0;
          ino_free[ino]  = 1'b0;
          first_blk[ino] = BLK_W'(blk);
          r.inode        = INO_W'(ino);
          r.block        = BLK_W'(blk);
        end
      end
      REQ_LOOKUP: begin
        if (int'(it.id) < INODE_TOTAL) r.block = first_blk[it.id];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_req(input req_t r, input int id);
    fs_req_t it;
    it.req = r;
    it.id  = INO_W'(id);
    waiting_items.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // driver: one item at a time, random gap drawn per item
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      hold = start;
      if (start && !busy) begin
        owed_replies.push_back(alloc_outcome(cur));
        items_taken++;
        case (cur.req)
          REQ_FORMAT: n_format++;
          REQ_CREATE: n_create++;
          REQ_LOOKUP: n_lookup++;
          default:    n_unused++;
        endcase
        if ($urandom_range(0, 29) == 0) steady = !steady;
        gap_left = steady ? 0 : $urandom_range(0, 6);
        hold     = 1'b0;
      end
      if (hold) begin
        // keep the item on the ports until taken
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (waiting_items.size() != 0) begin
        cur = waiting_items.pop_front();
        start    <= 1'b1;
        req_type <= cur.req;
        inode_id <= cur.id;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be stalled, take each strobe as it comes
  always @(posedge clk) begin
    fs_reply_t want;
    if (!rst && done) begin
      if (owed_replies.size() == 0) begin
        $error("reply with none outstanding: status %0d inode %0d block %0d",
               status, new_inode, block_number);
        errors++;
      end else begin
        want = owed_replies.pop_front();
        if (want.status == ST_NO_INODE) n_refused++;
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (new_inode !== want.inode) begin
          $error("new_inode: expected %0d, got %0d", want.inode, new_inode);
          errors++;
        end
        if (block_number !== want.block) begin
          $error("block_number: expected %0d, got %0d", want.block, block_number);
          errors++;
        end
      end
    end
  end

  initial begin
    int pick;
    format_maps();
    foreach (first_blk[i]) first_blk[i] = '0;

    // directed: empty table, unused type, allocation, format keeps the table
    queue_req(REQ_LOOKUP, 0);
    queue_req(REQ_LOOKUP, INODE_TOTAL - 1);
    queue_req(REQ_NONE, INODE_TOTAL - 1);
    queue_req(REQ_CREATE, INODE_TOTAL - 1);
    queue_req(REQ_CREATE, 0);
    queue_req(REQ_CREATE, 0);
    queue_req(REQ_LOOKUP, 0);
    queue_req(REQ_LOOKUP, 1);
    queue_req(REQ_LOOKUP, 2);
    queue_req(REQ_LOOKUP, 3);
    queue_req(REQ_FORMAT, INODE_TOTAL - 1);
    queue_req(REQ_LOOKUP, 1);
    queue_req(REQ_LOOKUP, 2);
    queue_req(REQ_CREATE, 0);
    queue_req(REQ_LOOKUP, 0);
    queue_req(REQ_NONE, 0);
    queue_req(REQ_CREATE, 0);
    queue_req(REQ_FORMAT, 0);

    // random mix, lookups mostly aimed at recently allocated inodes
    for (int i = 0; i < 520; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) queue_req(REQ_CREATE, $urandom_range(0, INODE_TOTAL - 1));
      else if (pick < 85)
        queue_req(REQ_LOOKUP, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31)
                                                         : $urandom_range(0, INODE_TOTAL - 1));
      else if (pick < 93) queue_req(REQ_NONE, $urandom_range(0, INODE_TOTAL - 1));
      else queue_req(REQ_FORMAT, $urandom_range(0, INODE_TOTAL - 1));
    end

    // format, then a few creates and lookups around it
    queue_req(REQ_FORMAT, 0);
    queue_req(REQ_CREATE, 0);
    queue_req(REQ_LOOKUP, INODE_TOTAL - 1);
    queue_req(REQ_CREATE, INODE_TOTAL - 1);
    queue_req(REQ_LOOKUP, $urandom_range(0, INODE_TOTAL - 1));
    queue_req(REQ_FORMAT, 0);
    queue_req(REQ_CREATE, 0);
    queue_req(REQ_LOOKUP, 0);
    queue_req(REQ_LOOKUP, INODE_TOTAL - 1);
    items_total = waiting_items.size();

    while (rst) @(posedge clk);
    while (items_taken < items_total) @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("ran %0d creates (%0d refused for lack of an inode), %0d lookups,",
             n_create, n_refused, n_lookup);
    $display("%0d formats and %0d unused requests; %0d mismatches",
             n_format, n_unused, errors);
    if (errors == 0) begin
      $display("bitmap_block_and_inode_allocator_core regression: pass");
    end else begin
      $display("bitmap_block_and_inode_allocator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("timeout with %0d of %0d items taken, %0d replies outstanding",
             items_taken, items_total, owed_replies.size());
    $display("bitmap_block_and_inode_allocator_core regression: fail");
    $finish;
  end

endmodule
